// ===== rtl/fat_geometry_type_probe_defines.svh =====
// Assertion macros used by the checker file fgtp_checker.sv.
`ifndef FAT_GEOMETRY_TYPE_PROBE_DEFINES_SVH
`define FAT_GEOMETRY_TYPE_PROBE_DEFINES_SVH

// Whenever ante holds at a clock edge, cons must hold at that same edge.
`define FGTP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// bad must never be seen at a clock edge outside reset.
`define FGTP_ASSERT_NEVER(label, clk, rst_n, bad, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
    else $error(msg);

`endif

// ===== rtl/fgtp_pkg.sv =====
package fgtp_pkg;

  localparam int DirEntryShift = 5;
  localparam int SecBytesW     = 16;
  localparam int RootNumW      = SecBytesW + DirEntryShift + 1;
  localparam int QuoW          = 32;
  localparam int DvsW          = 16;
  localparam int RootSteps     = RootNumW;
  localparam int ClusterSteps  = QuoW;
  // front stage + root cells + mid stage + cluster cells + output stage
  localparam int PipeDepth     = RootSteps + ClusterSteps + 3;

  localparam logic [31:0] Fat16MinClusters = 32'd4085;
  localparam logic [31:0] Fat32MinClusters = 32'd65525;

  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_ZERO_GEOM  = 3'd1;
  localparam logic [2:0] STATUS_ZERO_TOTAL = 3'd2;
  localparam logic [2:0] STATUS_ZERO_TABLE = 3'd3;
  localparam logic [2:0] STATUS_FAT12      = 3'd4;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] total;
    logic [15:0] rsv;
    logic [31:0] prod;
    logic [7:0]  spc;
    logic [31:0] root_sec;
  } fgtp_ctx_t;

  typedef struct packed {
    logic            valid;
    logic [DvsW-1:0] rem;
    logic [QuoW-1:0] acc;
    logic [DvsW-1:0] dvs;
    fgtp_ctx_t       ctx;
  } fgtp_lane_t;

endpackage

// ===== rtl/fgtp_div_cell.sv =====
module fgtp_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  fgtp_pkg::fgtp_lane_t lane_i,
  output fgtp_pkg::fgtp_lane_t lane_o
);
  import fgtp_pkg::*;

  logic [DvsW:0] trial;
  logic [DvsW:0] diff;
  logic          fits;
  fgtp_lane_t    lane_nxt;
  fgtp_lane_t    data_r;
  logic          valid_r;

  // one restoring step: bring in the next dividend bit, subtract when it fits
  always_comb begin
    trial    = {lane_i.rem, lane_i.acc[QuoW-1]};
    diff     = trial - {1'b0, lane_i.dvs};
    fits     = (trial >= {1'b0, lane_i.dvs});
    lane_nxt = lane_i;
    lane_nxt.rem = fits ? diff[DvsW-1:0] : trial[DvsW-1:0];
    lane_nxt.acc = {lane_i.acc[QuoW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= lane_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= lane_nxt;
  end

  always_comb begin
    lane_o       = data_r;
    lane_o.valid = valid_r;
  end

endmodule

// ===== rtl/fgtp_front.sv =====
module fgtp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [15:0]          sector_bytes,
  input  logic [7:0]           cluster_sectors,
  input  logic [15:0]          reserved_count,
  input  logic [7:0]           table_copies,
  input  logic [15:0]          total_small,
  input  logic [31:0]          total_large,
  input  logic [15:0]          table_size_small,
  input  logic [31:0]          table_size_large,
  input  logic [15:0]          root_entries,
  output fgtp_pkg::fgtp_lane_t lane_o
);
  import fgtp_pkg::*;

  logic                geom_zero;
  logic [31:0]         total_sel;
  logic [31:0]         fsz_sel;
  logic [15:0]         bps_m1;
  logic [RootNumW-1:0] root_num;
  logic [39:0]         prod_full;
  fgtp_lane_t          lane_nxt;
  fgtp_lane_t          data_r;
  logic                valid_r;

  always_comb begin
    geom_zero = (sector_bytes == 16'd0) || (cluster_sectors == 8'd0) ||
                (table_copies == 8'd0);
    total_sel = (total_small != 16'd0) ? {16'd0, total_small} : total_large;
    fsz_sel   = (table_size_small != 16'd0) ? {16'd0, table_size_small}
                                            : table_size_large;
    bps_m1    = sector_bytes - 16'd1;
    // entries * 32 + (bytes per sector - 1), rounds the division up
    root_num  = {1'b0, root_entries, {DirEntryShift{1'b0}}} +
                {{(RootNumW-SecBytesW){1'b0}}, bps_m1};
    prod_full = {32'd0, table_copies} * {8'd0, fsz_sel};

    lane_nxt       = '0;
    lane_nxt.valid = accept;
    lane_nxt.rem   = '0;
    lane_nxt.acc   = {root_num, {(QuoW-RootNumW){1'b0}}};
    lane_nxt.dvs   = sector_bytes;
    lane_nxt.ctx.total    = total_sel;
    lane_nxt.ctx.rsv      = reserved_count;
    lane_nxt.ctx.prod     = prod_full[31:0];
    lane_nxt.ctx.spc      = cluster_sectors;
    lane_nxt.ctx.root_sec = '0;
    if (geom_zero) begin
      lane_nxt.ctx.status = STATUS_ZERO_GEOM;
    end else if (total_sel == 32'd0) begin
      lane_nxt.ctx.status = STATUS_ZERO_TOTAL;
    end else if (fsz_sel == 32'd0) begin
      lane_nxt.ctx.status = STATUS_ZERO_TABLE;
    end else begin
      lane_nxt.ctx.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= lane_nxt;
  end

  always_comb begin
    lane_o       = data_r;
    lane_o.valid = valid_r;
  end

endmodule

// ===== rtl/fgtp_mid.sv =====
module fgtp_mid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fgtp_pkg::fgtp_lane_t lane_i,
  output fgtp_pkg::fgtp_lane_t lane_o
);
  import fgtp_pkg::*;

  logic [31:0] used;
  logic [31:0] data_secs;
  fgtp_lane_t  lane_nxt;
  fgtp_lane_t  data_r;
  logic        valid_r;

  // quotient of the root chain is the root directory size; launch cluster division
  always_comb begin
    used      = {16'd0, lane_i.ctx.rsv} + lane_i.ctx.prod + lane_i.acc;
    data_secs = lane_i.ctx.total - used;

    lane_nxt              = lane_i;
    lane_nxt.ctx.root_sec = lane_i.acc;
    lane_nxt.rem          = '0;
    lane_nxt.acc          = data_secs;
    lane_nxt.dvs          = {{(DvsW-8){1'b0}}, lane_i.ctx.spc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= lane_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= lane_nxt;
  end

  always_comb begin
    lane_o       = data_r;
    lane_o.valid = valid_r;
  end

endmodule

// ===== rtl/fgtp_back.sv =====
module fgtp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fgtp_pkg::fgtp_lane_t lane_i,
  output logic                 strobe,
  output logic [2:0]           status,
  output logic [1:0]           fat_kind,
  output logic [31:0]          sector_total,
  output logic [31:0]          root_sectors,
  output logic [31:0]          cluster_total
);
  import fgtp_pkg::*;

  logic        strobe_r;
  logic [2:0]  status_r,  status_nxt;
  logic [1:0]  kind_r,    kind_nxt;
  logic [31:0] total_r,   total_nxt;
  logic [31:0] root_r,    root_nxt;
  logic [31:0] clus_r,    clus_nxt;

  always_comb begin
    status_nxt = lane_i.ctx.status;
    kind_nxt   = KIND_NONE;
    total_nxt  = '0;
    root_nxt   = '0;
    clus_nxt   = '0;
    case (lane_i.ctx.status)
      STATUS_OK: begin
        total_nxt = lane_i.ctx.total;
        root_nxt  = lane_i.ctx.root_sec;
        clus_nxt  = lane_i.acc;
        if (lane_i.acc < Fat16MinClusters) begin
          status_nxt = STATUS_FAT12;
        end else if (lane_i.acc < Fat32MinClusters) begin
          kind_nxt = KIND_FAT16;
        end else begin
          kind_nxt = KIND_FAT32;
        end
      end
      STATUS_ZERO_TABLE: begin
        total_nxt = lane_i.ctx.total;
      end
      default: begin
        total_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= lane_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    kind_r   <= kind_nxt;
    total_r  <= total_nxt;
    root_r   <= root_nxt;
    clus_r   <= clus_nxt;
  end

  assign strobe        = strobe_r;
  assign status        = status_r;
  assign fat_kind      = kind_r;
  assign sector_total  = total_r;
  assign root_sectors  = root_r;
  assign cluster_total = clus_r;

endmodule

// ===== rtl/fat_geometry_type_probe.sv =====
// channel   | handshake          | payload
// ----------+--------------------+-----------------------------------------------
// request   | start, busy        | in_sector_bytes .. in_root_entries (9 fields)
// result    | out_strobe         | out_status, out_fat_kind, out_sector_total,
//           |                    | out_root_sectors, out_cluster_total
//
// One request per cycle; busy stays low. Each result passes through the pipeline:
// one front stage, 22 root-directory divide cells (one quotient bit each), a mid
// stage, 32 cluster divide cells and the output register.
// Reset clears only the valid bits of the cell chain; no clearing pass.
// The receiver cannot stall, so results leave in request order at full rate.
module fat_geometry_type_probe (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_sector_bytes,
  input  logic [7:0]  in_cluster_sectors,
  input  logic [15:0] in_reserved_count,
  input  logic [7:0]  in_table_copies,
  input  logic [15:0] in_total_small,
  input  logic [31:0] in_total_large,
  input  logic [15:0] in_table_size_small,
  input  logic [31:0] in_table_size_large,
  input  logic [15:0] in_root_entries,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [1:0]  out_fat_kind,
  output logic [31:0] out_sector_total,
  output logic [31:0] out_root_sectors,
  output logic [31:0] out_cluster_total
);
  import fgtp_pkg::*;

  fgtp_lane_t root_lane    [RootSteps+1];
  fgtp_lane_t cluster_lane [ClusterSteps+1];

  assign busy = 1'b0;

  fgtp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (start && !busy),
    .sector_bytes     (in_sector_bytes),
    .cluster_sectors  (in_cluster_sectors),
    .reserved_count   (in_reserved_count),
    .table_copies     (in_table_copies),
    .total_small      (in_total_small),
    .total_large      (in_total_large),
    .table_size_small (in_table_size_small),
    .table_size_large (in_table_size_large),
    .root_entries     (in_root_entries),
    .lane_o           (root_lane[0])
  );

  for (genvar i = 0; i < RootSteps; i++) begin : g_root
    fgtp_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .lane_i (root_lane[i]),
      .lane_o (root_lane[i+1])
    );
  end

  fgtp_mid u_mid (
    .clk    (clk),
    .rst_n  (rst_n),
    .lane_i (root_lane[RootSteps]),
    .lane_o (cluster_lane[0])
  );

  for (genvar j = 0; j < ClusterSteps; j++) begin : g_cluster
    fgtp_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .lane_i (cluster_lane[j]),
      .lane_o (cluster_lane[j+1])
    );
  end

  fgtp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .lane_i        (cluster_lane[ClusterSteps]),
    .strobe        (out_strobe),
    .status        (out_status),
    .fat_kind      (out_fat_kind),
    .sector_total  (out_sector_total),
    .root_sectors  (out_root_sectors),
    .cluster_total (out_cluster_total)
  );

endmodule

// ===== rtl/fgtp_checker.sv =====
`include "fat_geometry_type_probe_defines.svh"

module fgtp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [2:0]  out_status,
  input logic [1:0]  out_fat_kind,
  input logic [31:0] out_sector_total,
  input logic [31:0] out_root_sectors,
  input logic [31:0] out_cluster_total
);
  import fgtp_pkg::*;

  localparam int CntW = $clog2(PipeDepth + 1);
  localparam logic [CntW-1:0] WarmFull = CntW'(PipeDepth);

  logic [CntW-1:0] warm_cnt_r, warm_cnt_nxt;

  // count edges since reset, hold once the pipeline is fully refilled
  assign warm_cnt_nxt = (warm_cnt_r == WarmFull) ? warm_cnt_r : warm_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_cnt_r <= '0;
    end else begin
      warm_cnt_r <= warm_cnt_nxt;
    end
  end

  `FGTP_ASSERT_IMPLIES(a_geom_zeroes, clk, rst_n, out_strobe && out_status == STATUS_ZERO_GEOM, out_fat_kind == KIND_NONE && out_sector_total == 32'd0 && out_root_sectors == 32'd0 && out_cluster_total == 32'd0, "zero geometry result carries nonzero fields")
  `FGTP_ASSERT_IMPLIES(a_fat12_range, clk, rst_n, out_strobe && out_status == STATUS_FAT12, out_fat_kind == KIND_NONE && out_cluster_total < Fat16MinClusters, "FAT12 flag disagrees with cluster count")
  `FGTP_ASSERT_IMPLIES(a_fat32_range, clk, rst_n, out_strobe && out_fat_kind == KIND_FAT32, out_status == STATUS_OK && out_cluster_total >= Fat32MinClusters, "FAT32 kind disagrees with cluster count")
  `FGTP_ASSERT_IMPLIES(a_one_per_request, clk, rst_n, warm_cnt_r == WarmFull, out_strobe == $past(start && !busy, PipeDepth), "result strobe does not match request latency")

endmodule

bind fat_geometry_type_probe fgtp_checker u_fgtp_checker (.*);
